/* rtl/cidq_pkg.sv */
// Package for the circular identifier queue with find and delete.
// Holds the ring geometry, the action and status codes and the pointer helpers.
// No dependencies.
package cidq_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int PID_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 6;

    localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DEL  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd3;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Step a ring pointer forward with wrap.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Step a ring pointer back with wrap.
    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        ptr_prev = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    // Ring distance from a to b, that is (b - a) mod DEPTH.
    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] diff;
        diff = {1'b0, b} - {1'b0, a};
        if (b < a) begin
            diff = diff + (PTR_W+1)'(DEPTH);
        end
        ptr_dist = diff[PTR_W-1:0];
    endfunction

endpackage

/* rtl/cidq_in_if.sv */
// Request channel of the circular identifier queue: valid, ready and one beat.
// Depends on cidq_pkg for the field widths.
interface cidq_in_if;
    logic                           valid;
    logic                           ready;
    logic [cidq_pkg::ACT_W-1:0]     action;
    logic [cidq_pkg::PID_W-1:0]     pid;
    logic [cidq_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, action, pid, slot, input ready);
    modport sink   (input valid, action, pid, slot, output ready);
endinterface

/* rtl/cidq_out_if.sv */
// Result channel of the circular identifier queue: valid, ready and one beat.
// Depends on cidq_pkg for the field widths.
interface cidq_out_if;
    logic                           valid;
    logic                           ready;
    logic [cidq_pkg::PID_W-1:0]     pid_out;
    logic [cidq_pkg::SLOT_W-1:0]    slot_out;
    logic [cidq_pkg::STAT_W-1:0]    status;
    logic [cidq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, pid_out, slot_out, status, occupancy, input ready);
    modport sink   (input valid, pid_out, slot_out, status, occupancy, output ready);
endinterface

/* rtl/circular_id_queue_find_delete.sv */
// Circular queue of 16-bit identifiers with enqueue, dequeue, find and delete.
// Depends on cidq_pkg, cidq_in_if and cidq_out_if.
//
// Usage: each request beat on i_in carries an action, an identifier and a slot.
// Every request produces exactly one result beat on o_out with the dequeued
// identifier, the slot found, a status code and the occupancy after the action.
// The ring has 64 slots in a single-port-write, registered-read memory and holds
// up to 63 entries. One request is worked on at a time; i_in.ready is high only
// while the sequencer is idle.
// A find compares entries from the head toward the tail until a match or the tail;
// a delete moves each entry after the deleted slot one slot toward the head, then
// steps the tail back. A refused request goes straight to the result. The memory's
// single read port is walked one slot per cycle by the find and delete loop.
// Reset clears head, tail and all handshake state; the ring contents are not
// cleared, since only slots written before are ever read. There is no clearing
// pass. The result sits in an output register; if the receiver stalls, a
// finished result waits there, the next request can still be taken and worked
// on, and its result is held inside until the output register frees up.
module circular_id_queue_find_delete (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cidq_in_if.sink      i_in,
    cidq_out_if.source   o_out
);

    localparam int PTR_W  = cidq_pkg::PTR_W;
    localparam int PID_W  = cidq_pkg::PID_W;
    localparam int SLOT_W = cidq_pkg::SLOT_W;
    localparam int STAT_W = cidq_pkg::STAT_W;
    localparam int OCC_W  = cidq_pkg::OCC_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEQ_RD = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_DEL    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    // Ring storage with a registered read port.
    logic [PID_W-1:0] r_mem [cidq_pkg::DEPTH];
    logic [PID_W-1:0] r_rdata;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [PID_W-1:0] mem_wdata;
    logic [PTR_W-1:0] mem_raddr;

    // Control state.
    logic [2:0]       r_state,  n_state;
    logic [PTR_W-1:0] r_head,   n_head;
    logic [PTR_W-1:0] r_tail,   n_tail;
    logic [PTR_W-1:0] r_ptr,    n_ptr;     // next slot to read in a walk
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;  // slot whose data is in r_rdata
    logic             r_rd_vld, n_rd_vld;  // r_rdata holds a walk read
    logic [PID_W-1:0] r_key,    n_key;     // identifier searched for

    // Result held until the output register takes it.
    logic [PID_W-1:0]  r_res_pid,    n_res_pid;
    logic [SLOT_W-1:0] r_res_slot,   n_res_slot;
    logic [STAT_W-1:0] r_res_status, n_res_status;

    // Output register.
    logic              r_out_valid,  n_out_valid;
    logic [PID_W-1:0]  r_out_pid,    n_out_pid;
    logic [SLOT_W-1:0] r_out_slot,   n_out_slot;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [OCC_W-1:0]  r_out_occ,    n_out_occ;

    logic [PTR_W-1:0]  count;
    logic [PTR_W-1:0]  del_offset;
    logic              in_beat;
    logic              out_free;

    assign count      = cidq_pkg::ptr_dist(r_head, r_tail);
    assign del_offset = cidq_pkg::ptr_dist(r_head, i_in.slot[PTR_W-1:0]);
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.pid_out   = r_out_pid;
    assign o_out.slot_out  = r_out_slot;
    assign o_out.status    = r_out_status;
    assign o_out.occupancy = r_out_occ;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ptr        = r_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_rd_vld     = r_rd_vld;
        n_key        = r_key;
        n_res_pid    = r_res_pid;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pid    = r_out_pid;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        mem_we       = 1'b0;
        mem_waddr    = r_tail;
        mem_wdata    = i_in.pid;
        mem_raddr    = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_res_pid    = '0;
                    n_res_slot   = '0;
                    n_res_status = cidq_pkg::ST_OK;
                    n_key        = i_in.pid;
                    n_rd_vld     = 1'b0;
                    n_state      = S_RESULT;
                    case (i_in.action)
                        cidq_pkg::ACT_ENQ: begin
                            if (count == cidq_pkg::PTR_LAST) begin
                                n_res_status = cidq_pkg::ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_tail = cidq_pkg::ptr_next(r_tail);
                            end
                        end
                        cidq_pkg::ACT_DEQ: begin
                            if (count == '0) begin
                                n_res_status = cidq_pkg::ST_EMPTY;
                            end else begin
                                mem_raddr = r_head;
                                n_state   = S_DEQ_RD;
                            end
                        end
                        cidq_pkg::ACT_FIND: begin
                            n_ptr   = r_head;
                            n_state = S_FIND;
                        end
                        default: begin
                            // Delete: the slot must lie between head and tail.
                            if ((SLOT_W > PTR_W &&
                                 (i_in.slot >> PTR_W) != '0) ||
                                del_offset >= count) begin
                                n_res_status = cidq_pkg::ST_NOSLOT;
                            end else begin
                                n_rd_ptr = i_in.slot[PTR_W-1:0];
                                n_ptr    = cidq_pkg::ptr_next(i_in.slot[PTR_W-1:0]);
                                n_state  = S_DEL;
                            end
                        end
                    endcase
                end
            end

            S_DEQ_RD: begin
                n_res_pid = r_rdata;
                n_head    = cidq_pkg::ptr_next(r_head);
                n_state   = S_RESULT;
            end

            S_FIND: begin
                // One read issued and one compare done each cycle.
                if (r_rd_vld && r_rdata == r_key) begin
                    n_res_slot = SLOT_W'(r_rd_ptr);
                    n_rd_vld   = 1'b0;
                    n_state    = S_RESULT;
                end else if (r_ptr == r_tail) begin
                    n_res_status = cidq_pkg::ST_EMPTY;
                    n_rd_vld     = 1'b0;
                    n_state      = S_RESULT;
                end else begin
                    mem_raddr = r_ptr;
                    n_rd_ptr  = r_ptr;
                    n_rd_vld  = 1'b1;
                    n_ptr     = cidq_pkg::ptr_next(r_ptr);
                end
            end

            S_DEL: begin
                // Each entry read last cycle is written one slot toward the head.
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = cidq_pkg::ptr_prev(r_rd_ptr);
                    mem_wdata = r_rdata;
                end
                if (r_ptr == r_tail) begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_tail  = cidq_pkg::ptr_prev(r_tail);
                        n_state = S_RESULT;
                    end
                end else begin
                    mem_raddr = r_ptr;
                    n_rd_ptr  = r_ptr;
                    n_rd_vld  = 1'b1;
                    n_ptr     = cidq_pkg::ptr_next(r_ptr);
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pid    = r_res_pid;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_out_occ    = OCC_W'(count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_rd_ptr     <= n_rd_ptr;
        r_key        <= n_key;
        r_res_pid    <= n_res_pid;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_pid    <= n_out_pid;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

endmodule
